// ----- hw/rtl/cacc_platoon_accel_controller_assert.svh -----
// assertion macros for the platoon acceleration controller
`ifndef CACC_PLATOON_ACCEL_CONTROLLER_ASSERT_SVH
`define CACC_PLATOON_ACCEL_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CACC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CACC_ASSERT(lbl, prop, msg) `CACC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define CACC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CACC_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/cacc_pkg.sv -----
// shared types and constants for the platoon acceleration controller
package cacc_pkg;

    localparam int NEIGHBOR_SLOTS = 16;
    localparam int SLOT_W         = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int CNT_W          = $clog2(NEIGHBOR_SLOTS + 1);
    localparam int GAIN_FRAC_BITS = 10;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int COEF_W         = GAIN_W + 1;
    localparam int OPND_W         = 34;
    localparam int PROD_W         = COEF_W + OPND_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int VAL_W          = 16;
    localparam int ADDR_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int ENTRY_W        = 5 * VAL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_FRONT_ACCEL  = 3'd0,
        CFG_GAIN_LEADER_ACCEL = 3'd1,
        CFG_GAIN_REL_SPEED    = 3'd2,
        CFG_GAIN_LEADER_SPEED = 3'd3,
        CFG_GAIN_SPACING      = 3'd4,
        CFG_LAG_FACTOR        = 3'd5,
        CFG_SPACING_OFFSET    = 3'd6,
        CFG_BEACON_ENABLE     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LSRC_NONE   = 2'd0,
        LSRC_DIRECT = 2'd1,
        LSRC_RELAY  = 2'd2
    } t_lsrc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_FRONT,
        ST_RD_LEAD,
        ST_CAP_LEAD,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        TERM_FA,
        TERM_LA,
        TERM_REL,
        TERM_LSD,
        TERM_SERR,
        TERM_LAG,
        TERM_PREV
    } t_term;

    typedef enum logic [1:0] {
        RSEL_SCAN,
        RSEL_FRONT,
        RSEL_LEAD
    } t_rsel;

    typedef struct packed {
        logic              msg_write;
        logic              upd_start;
        logic              scan_issue;
        logic [SLOT_W-1:0] scan_addr;
        t_rsel             rd_sel;
        logic              cap_front;
        logic              cap_lead;
        logic              mul_go;
        logic              acc_go;
        t_term             term;
        logic              finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- hw/rtl/cacc_datapath.sv -----
// neighbor table, front/leader search registers, shared multiplier and output register
module cacc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [cacc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cacc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [cacc_pkg::ADDR_W-1:0]      i_source_address,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_sender_speed,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_sender_accel,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_distance_to_me,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_relayed_leader_speed,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_relayed_leader_accel,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_own_speed,
    input  cacc_pkg::t_ctrl_cmd              i_cmd,
    output cacc_pkg::t_dp_status             o_status,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic signed [cacc_pkg::VAL_W-1:0] o_accel_command,
    output logic                             o_front_found,
    output logic [1:0]                       o_leader_source,
    output logic                             o_table_overflowed
);
    import cacc_pkg::*;

    localparam int RSH = 2 * GAIN_FRAC_BITS;

    // configuration registers
    logic [GAIN_W-1:0] r_g_fa, r_g_la, r_g_rel, r_g_lsd, r_g_serr, r_lag;
    logic [VAL_W-1:0]  r_offset;
    logic              r_beacon;

    // neighbor table
    logic [NEIGHBOR_SLOTS-1:0] r_valid;
    logic [ADDR_W-1:0]         r_src [NEIGHBOR_SLOTS];
    logic [ENTRY_W-1:0]        mem   [NEIGHBOR_SLOTS];
    logic [ENTRY_W-1:0]        r_rdata;
    logic [SLOT_W-1:0]         rd_addr;

    // message slot lookup
    logic              hit_ok, free_ok, wr_en;
    logic [SLOT_W-1:0] hit_idx, free_idx, wr_idx;
    logic              lead_ok;
    logic [SLOT_W-1:0] lead_idx;

    // update state
    logic signed [VAL_W-1:0] r_own, r_prev, r_fdist, r_fs, r_fa, r_rls, r_rla, r_ls, r_la;
    logic                    r_ovf, r_any, r_ffound, r_lead_ok, r_rd_vld;
    logic [SLOT_W-1:0]       r_lead_idx, r_fidx, r_rd_idx;
    t_lsrc                   r_lsrc;
    logic signed [VAL_W-1:0] scan_dist;

    // arithmetic
    logic signed [COEF_W-1:0] coef;
    logic signed [OPND_W-1:0] opnd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OPND_W-1:0] r_sum;
    logic signed [ACC_W-1:0]  r_tot, rnd, shd;
    logic signed [VAL_W-1:0]  sat, cmd_val;

    // output register
    logic                    r_out_vld, r_out_ff, r_out_ovf;
    logic signed [VAL_W-1:0] r_out_cmd;
    t_lsrc                   r_out_lsrc;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_fa   <= GAIN_W'(512);
            r_g_la   <= GAIN_W'(512);
            r_g_rel  <= GAIN_W'(307);
            r_g_lsd  <= GAIN_W'(102);
            r_g_serr <= GAIN_W'(41);
            r_lag    <= GAIN_W'(819);
            r_offset <= VAL_W'(1024);
            r_beacon <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_FRONT_ACCEL:  r_g_fa   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_LEADER_ACCEL: r_g_la   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_REL_SPEED:    r_g_rel  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_LEADER_SPEED: r_g_lsd  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_SPACING:      r_g_serr <= i_cfg_data[GAIN_W-1:0];
                CFG_LAG_FACTOR:        r_lag    <= i_cfg_data[GAIN_W-1:0];
                CFG_SPACING_OFFSET:    r_offset <= i_cfg_data[VAL_W-1:0];
                CFG_BEACON_ENABLE:     r_beacon <= i_cfg_data[0];
                default:               r_beacon <= r_beacon;
            endcase
        end
    end

    // priority search over the slot lanes, lowest slot wins
    always_comb begin
        hit_ok   = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        lead_ok  = 1'b0;
        lead_idx = '0;
        for (int i = NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_src[i] == i_source_address) begin
                hit_ok  = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (r_valid[i] && r_src[i] == '0) begin
                lead_ok  = 1'b1;
                lead_idx = SLOT_W'(i);
            end
        end
        wr_en  = i_cmd.msg_write && (hit_ok || free_ok);
        wr_idx = hit_ok ? hit_idx : free_idx;
    end

    // table valid bits, sources and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_valid <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.msg_write) begin
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_src[wr_idx] <= i_source_address;
        end
    end

    // entry memory: speed, accel, distance, relayed speed, relayed accel
    always_comb begin
        case (i_cmd.rd_sel)
            RSEL_SCAN:  rd_addr = i_cmd.scan_addr;
            RSEL_FRONT: rd_addr = r_fidx;
            RSEL_LEAD:  rd_addr = r_lead_idx;
            default:    rd_addr = i_cmd.scan_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= {i_relayed_leader_accel, i_relayed_leader_speed,
                            i_distance_to_me, i_sender_accel, i_sender_speed};
        end
        r_rdata <= mem[rd_addr];
    end

    assign scan_dist = r_rdata[3*VAL_W-1:2*VAL_W];

    // update start and front vehicle scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_ffound <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.upd_start) begin
                r_ffound <= 1'b0;
            end else if (r_rd_vld && r_valid[r_rd_idx] && scan_dist > 0
                         && (!r_ffound || scan_dist < r_fdist)) begin
                r_ffound <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.scan_addr;
        if (i_cmd.upd_start) begin
            r_own      <= i_own_speed;
            r_any      <= |r_valid;
            r_lead_ok  <= lead_ok;
            r_lead_idx <= lead_idx;
        end else if (r_rd_vld && r_valid[r_rd_idx] && scan_dist > 0
                     && (!r_ffound || scan_dist < r_fdist)) begin
            r_fidx  <= r_rd_idx;
            r_fdist <= scan_dist;
        end
    end

    // capture front and leader entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_front) begin
            r_fs  <= r_rdata[VAL_W-1:0];
            r_fa  <= r_rdata[2*VAL_W-1:VAL_W];
            r_rls <= r_rdata[4*VAL_W-1:3*VAL_W];
            r_rla <= r_rdata[5*VAL_W-1:4*VAL_W];
        end
        if (i_cmd.cap_lead) begin
            if (r_lead_ok) begin
                r_ls   <= r_rdata[VAL_W-1:0];
                r_la   <= r_rdata[2*VAL_W-1:VAL_W];
                r_lsrc <= LSRC_DIRECT;
            end else if (r_ffound && r_beacon) begin
                r_ls   <= r_rls;
                r_la   <= r_rla;
                r_lsrc <= LSRC_RELAY;
            end else begin
                r_ls   <= '0;
                r_la   <= '0;
                r_lsrc <= LSRC_NONE;
            end
        end
    end

    // coefficient and operand for the shared multiplier
    always_comb begin
        case (i_cmd.term)
            TERM_FA: begin
                coef = $signed(COEF_W'(r_g_fa));
                opnd = r_ffound ? OPND_W'(r_fa) : '0;
            end
            TERM_LA: begin
                coef = $signed(COEF_W'(r_g_la));
                opnd = OPND_W'(r_la);
            end
            TERM_REL: begin
                coef = $signed(COEF_W'(r_g_rel));
                opnd = r_ffound ? OPND_W'(r_own) - OPND_W'(r_fs) : '0;
            end
            TERM_LSD: begin
                coef = $signed(COEF_W'(r_g_lsd));
                opnd = OPND_W'(r_own) - OPND_W'(r_ls);
            end
            TERM_SERR: begin
                coef = $signed(COEF_W'(r_g_serr));
                opnd = r_ffound ? $signed(OPND_W'(r_offset)) - OPND_W'(r_fdist) : '0;
            end
            TERM_LAG: begin
                coef = $signed(COEF_W'(r_lag));
                opnd = r_sum;
            end
            TERM_PREV: begin
                coef = $signed(COEF_W'(1 << GAIN_FRAC_BITS)) - $signed(COEF_W'(r_lag));
                opnd = OPND_W'(r_prev);
            end
            default: begin
                coef = '0;
                opnd = '0;
            end
        endcase
    end

    // multiply, then accumulate in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= coef * opnd;
        end
        if (i_cmd.upd_start) begin
            r_sum <= '0;
        end else if (i_cmd.acc_go) begin
            case (i_cmd.term)
                TERM_FA, TERM_LA:            r_sum <= r_sum + OPND_W'(r_prod);
                TERM_REL, TERM_LSD, TERM_SERR: r_sum <= r_sum - OPND_W'(r_prod);
                TERM_LAG:                    r_tot <= ACC_W'(r_prod);
                TERM_PREV:                   r_tot <= r_tot + (ACC_W'(r_prod) <<< GAIN_FRAC_BITS);
                default:                     r_sum <= r_sum;
            endcase
        end
    end

    // round half up, floor shift and saturate
    always_comb begin
        rnd = r_tot + (ACC_W'(1) <<< (RSH - 1));
        shd = rnd >>> RSH;
        if (shd > ACC_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (shd < -ACC_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = shd[VAL_W-1:0];
        end
        cmd_val = r_any ? sat : r_prev;
    end

    // result register and previous command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_prev    <= '0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
            r_prev    <= cmd_val;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_cmd  <= cmd_val;
            r_out_ff   <= r_any && r_ffound;
            r_out_lsrc <= r_any ? r_lsrc : LSRC_NONE;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_status.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid        = r_out_vld;
    assign o_accel_command    = r_out_cmd;
    assign o_front_found      = r_out_ff;
    assign o_leader_source    = r_out_lsrc;
    assign o_table_overflowed = r_out_ovf;

endmodule

// ----- hw/rtl/cacc_ctrl.sv -----
// controller state machine sequencing scan, reads and multiply steps
module cacc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_func,
    output logic                 o_in_stall,
    output cacc_pkg::t_ctrl_cmd  o_cmd,
    input  cacc_pkg::t_dp_status i_status
);
    import cacc_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_term             r_term, n_term;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_term  <= TERM_FA;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_term  = r_term;
        o_cmd   = '0;
        o_cmd.rd_sel    = RSEL_SCAN;
        o_cmd.scan_addr = r_cnt[SLOT_W-1:0];
        o_cmd.term      = r_term;
        o_in_stall      = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_func) begin
                        o_cmd.upd_start = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.msg_write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_W'(NEIGHBOR_SLOTS)) begin
                    n_state = ST_RD_FRONT;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RD_FRONT: begin
                o_cmd.rd_sel = RSEL_FRONT;
                n_state = ST_RD_LEAD;
            end
            ST_RD_LEAD: begin
                o_cmd.rd_sel    = RSEL_LEAD;
                o_cmd.cap_front = 1'b1;
                n_state = ST_CAP_LEAD;
            end
            ST_CAP_LEAD: begin
                o_cmd.cap_lead = 1'b1;
                n_term  = TERM_FA;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_go = 1'b1;
                case (r_term)
                    TERM_FA:   n_term = TERM_LA;
                    TERM_LA:   n_term = TERM_REL;
                    TERM_REL:  n_term = TERM_LSD;
                    TERM_LSD:  n_term = TERM_SERR;
                    TERM_SERR: n_term = TERM_LAG;
                    TERM_LAG:  n_term = TERM_PREV;
                    default:   n_term = TERM_FA;
                endcase
                n_state = (r_term == TERM_PREV) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/cacc_platoon_accel_controller.sv -----
// Platoon acceleration controller top level. A neighbor message is written when it is taken:
// it overwrites the slot of its source or fills the lowest free slot, or sets the overflow
// flag when the table is full. During an update the entry memory's single read port is
// stepped through every slot to find the nearest vehicle ahead, the front and leader
// entries are then read, and seven products go one at a time through a shared 12 x 34
// bit multiplier. One update is in flight at a time; a finished result waits in the
// output register while new messages are taken. Configuration writes are always ready.
`include "cacc_platoon_accel_controller_assert.svh"
module cacc_platoon_accel_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cacc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cacc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [cacc_pkg::ADDR_W-1:0]       i_source_address,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_sender_speed,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_sender_accel,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_distance_to_me,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_relayed_leader_speed,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_relayed_leader_accel,
    input  logic signed [cacc_pkg::VAL_W-1:0] i_own_speed,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [cacc_pkg::VAL_W-1:0] o_accel_command,
    output logic                              o_front_found,
    output logic [1:0]                        o_leader_source,
    output logic                              o_table_overflowed
);
    import cacc_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    cacc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_func),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // table, arithmetic and result register
    cacc_datapath u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_source_address       (i_source_address),
        .i_sender_speed         (i_sender_speed),
        .i_sender_accel         (i_sender_accel),
        .i_distance_to_me       (i_distance_to_me),
        .i_relayed_leader_speed (i_relayed_leader_speed),
        .i_relayed_leader_accel (i_relayed_leader_accel),
        .i_own_speed            (i_own_speed),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_accel_command        (o_accel_command),
        .o_front_found          (o_front_found),
        .o_leader_source        (o_leader_source),
        .o_table_overflowed     (o_table_overflowed)
    );

    // an accepted update keeps the input stalled while it runs
    `CACC_ASSERT(a_update_busy, (i_in_valid && !o_in_stall && i_func) |=> o_in_stall, "update not busy")
    // a relayed leader needs a front vehicle
    `CACC_ASSERT(a_relay_front, (o_out_valid && o_leader_source == LSRC_RELAY) |-> o_front_found, "relay without front")
    // leader source code stays within its range
    `CACC_ASSERT_CLK(a_lsrc_range, i_clk, i_rst_n, o_out_valid |-> (o_leader_source <= LSRC_RELAY), "bad leader source")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the platoon acceleration controller
module tb;
    import cacc_pkg::*;

    // one input transaction, with an optional hand-written expectation
    typedef struct {
        logic                    func;
        logic [ADDR_W-1:0]       src;
        logic signed [VAL_W-1:0] spd;
        logic signed [VAL_W-1:0] acc;
        logic signed [VAL_W-1:0] dst;
        logic signed [VAL_W-1:0] rls;
        logic signed [VAL_W-1:0] rla;
        logic signed [VAL_W-1:0] own;
        logic                    fixed;
        logic signed [VAL_W-1:0] fixed_cmd;
    } t_stim;

    typedef struct {
        logic signed [VAL_W-1:0] cmd;
        logic                    front;
        t_lsrc                   lsrc;
        logic                    ovf;
    } t_accel_result;

    typedef struct {
        logic                    valid;
        logic [ADDR_W-1:0]       src;
        logic signed [VAL_W-1:0] spd;
        logic signed [VAL_W-1:0] acc;
        logic signed [VAL_W-1:0] dst;
        logic signed [VAL_W-1:0] lspd;
        logic signed [VAL_W-1:0] lacc;
    } t_neighbor;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_func;
    logic [ADDR_W-1:0]       i_source_address;
    logic signed [VAL_W-1:0] i_sender_speed;
    logic signed [VAL_W-1:0] i_sender_accel;
    logic signed [VAL_W-1:0] i_distance_to_me;
    logic signed [VAL_W-1:0] i_relayed_leader_speed;
    logic signed [VAL_W-1:0] i_relayed_leader_accel;
    logic signed [VAL_W-1:0] i_own_speed;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [VAL_W-1:0] o_accel_command;
    logic                    o_front_found;
    logic [1:0]              o_leader_source;
    logic                    o_table_overflowed;

    cacc_platoon_accel_controller u_dut (.*);

    // predictor state
    logic [15:0]             gain_reg [8];
    t_neighbor               neighbors [NEIGHBOR_SLOTS];
    logic signed [VAL_W-1:0] last_cmd;
    logic                    dropped;
    t_accel_result           pending_cmds [$];

    int    errors = 0;
    int    results_seen = 0;
    int    stall_left = 0;
    int    long_hold = 0;
    bit    quiet_sender = 0;
    bit    quiet_receiver = 0;
    longint cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // store a neighbor message in the predictor table
    function automatic void absorb_message(t_stim s);
        int hit;
        int free_slot;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
            if (neighbors[i].valid && neighbors[i].src == s.src && hit < 0) hit = i;
            if (!neighbors[i].valid && free_slot < 0) free_slot = i;
        end
        if (hit < 0) hit = free_slot;
        if (hit < 0) begin
            dropped = 1'b1;
        end else begin
            neighbors[hit] = '{1'b1, s.src, s.spd, s.acc, s.dst, s.rls, s.rla};
        end
    endfunction

    // acceleration law, lag and saturation for one update
    function automatic t_accel_result predict_update(logic signed [VAL_W-1:0] own_in);
        t_accel_result r;
        int     lead;
        int     front;
        bit     any;
        longint own, fa, la, rel, serr, ls, sum, lag, total, q;
        lead = -1;
        front = -1;
        any = 0;
        fa = 0; la = 0; rel = 0; serr = 0; ls = 0;
        own = longint'(own_in);
        r.lsrc = LSRC_NONE;
        for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
            if (neighbors[i].valid) begin
                any = 1;
                if (neighbors[i].src == 0 && lead < 0) lead = i;
                if (neighbors[i].dst > 0 &&
                    (front < 0 || neighbors[i].dst < neighbors[front].dst)) front = i;
            end
        end
        if (!any) begin
            r.cmd = last_cmd;
        end else begin
            if (front >= 0) begin
                rel  = own - longint'(neighbors[front].spd);
                fa   = longint'(neighbors[front].acc);
                serr = longint'(gain_reg[CFG_SPACING_OFFSET]) - longint'(neighbors[front].dst);
            end
            if (lead >= 0) begin
                ls = longint'(neighbors[lead].spd);
                la = longint'(neighbors[lead].acc);
                r.lsrc = LSRC_DIRECT;
            end else if (front >= 0 && gain_reg[CFG_BEACON_ENABLE][0]) begin
                ls = longint'(neighbors[front].lspd);
                la = longint'(neighbors[front].lacc);
                r.lsrc = LSRC_RELAY;
            end
            sum = longint'(gain_reg[CFG_GAIN_FRONT_ACCEL]) * fa
                + longint'(gain_reg[CFG_GAIN_LEADER_ACCEL]) * la
                - longint'(gain_reg[CFG_GAIN_REL_SPEED]) * rel
                - longint'(gain_reg[CFG_GAIN_LEADER_SPEED]) * (own - ls)
                - longint'(gain_reg[CFG_GAIN_SPACING]) * serr;
            lag = longint'(gain_reg[CFG_LAG_FACTOR]);
            total = lag * sum + (64'sd1024 - lag) * longint'(last_cmd) * 64'sd1024;
            q = (total + (64'sd1 <<< 19)) >>> 20;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            r.cmd = q[15:0];
        end
        r.front = (front >= 0);
        r.ovf = dropped;
        last_cmd = r.cmd;
        dropped = 1'b0;
        foreach (neighbors[i]) neighbors[i].valid = 1'b0;
        return r;
    endfunction

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_accel_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result transaction cmd=%0d", o_accel_command);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_accel_command !== want.cmd) begin
                    $error("accel_command expected %0d got %0d", want.cmd, o_accel_command);
                    errors++;
                end
                if (o_front_found !== want.front) begin
                    $error("front_found expected %0d got %0d", want.front, o_front_found);
                    errors++;
                end
                if (o_leader_source !== want.lsrc) begin
                    $error("leader_source expected %0d got %0d", want.lsrc, o_leader_source);
                    errors++;
                end
                if (o_table_overflowed !== want.ovf) begin
                    $error("table_overflowed expected %0d got %0d", want.ovf,
                           o_table_overflowed);
                    errors++;
                end
            end
            results_seen++;
            if (results_seen == 40) long_hold = 400;
            stall_left = quiet_receiver ? 0 : $urandom_range(0, 9);
        end
    end

    // output stall driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold > 0) begin
            i_out_stall <= 1'b1;
            long_hold--;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // offer one transaction and update the predictor once it is taken
    task automatic send_item(t_stim s);
        int gap;
        t_accel_result r;
        gap = quiet_sender ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid             <= 1'b1;
        i_func                 <= s.func;
        i_source_address       <= s.src;
        i_sender_speed         <= s.spd;
        i_sender_accel         <= s.acc;
        i_distance_to_me       <= s.dst;
        i_relayed_leader_speed <= s.rls;
        i_relayed_leader_accel <= s.rla;
        i_own_speed            <= s.own;
        do @(posedge i_clk); while (o_in_stall);
        if (s.func) begin
            r = predict_update(s.own);
            if (s.fixed) r = '{s.fixed_cmd, 1'b0, LSRC_NONE, 1'b0};
            pending_cmds.insert(pending_cmds.size(), r);
        end else begin
            absorb_message(s);
        end
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            gain_reg[i] = (i == CFG_SPACING_OFFSET) ? vals[i] :
                          (i == CFG_BEACON_ENABLE) ? {15'd0, vals[i][0]} : {5'd0, vals[i][10:0]};
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_distance();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(1, 8) * 16);
            1: return 16'($urandom_range(1, 600));
            2: return -$signed(16'($urandom_range(0, 600)));
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_stim rand_message(int pool);
        t_stim s;
        s.func = 1'b0;
        s.src = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, pool));
        s.spd = 16'($urandom);
        s.acc = 16'($urandom);
        s.dst = rand_distance();
        s.rls = 16'($urandom);
        s.rla = 16'($urandom);
        s.own = 16'($urandom);
        s.fixed = 1'b0;
        s.fixed_cmd = '0;
        return s;
    endfunction

    // directed rows: extremes, overwrite, missing leader or front, empty table
    t_stim directed [15] = '{
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{1'b0, 8'd0,   16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd5,   -16'sd32768, 16'sd32767, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd6,   16'sd100, 16'sd50, 16'sd1, 16'sd7, 16'sd9, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd7,   16'sd300, 16'sd20, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd8,   16'sd400, -16'sd20, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd5,   16'sd256, -16'sd256, 16'sd512, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, 16'sd0},
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100, 1'b0, 16'sd0},
        '{1'b0, 8'd255, 16'sd2000, 16'sd30, 16'sd300, -16'sd32768, 16'sd32767, 16'sd0,
          1'b0, 16'sd0},
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0, 16'sd0},
        '{1'b0, 8'd0,   16'sd1500, -16'sd64, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 8'd3,   16'sd900, 16'sd10, -16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{1'b1, 8'd0,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, 1'b0, 16'sd0}
    };

    // main sequence
    initial begin
        logic [15:0] phase_cfg [8];
        t_stim s;
        int    sent;
        int    burst;
        int    pool;
        gain_reg = '{16'd512, 16'd512, 16'd307, 16'd102, 16'd41, 16'd819, 16'd1024, 16'd0};
        foreach (neighbors[i]) neighbors[i].valid = 1'b0;
        last_cmd = '0;
        dropped = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func = 1'b0;
        i_source_address = '0;
        i_sender_speed = '0;
        i_sender_accel = '0;
        i_distance_to_me = '0;
        i_relayed_leader_speed = '0;
        i_relayed_leader_accel = '0;
        i_own_speed = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) send_item(directed[k]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: phase_cfg = '{16'd2047, 16'd2047, 16'd2047, 16'd2047, 16'd2047, 16'd2047,
                                 16'd65535, 16'd1};
                1: phase_cfg = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                2: phase_cfg = '{16'd1024, 16'd1024, 16'd1024, 16'd1024, 16'd1024, 16'd1024,
                                 16'd0, 16'd1};
                default: begin
                    for (int i = 0; i < 6; i++) phase_cfg[i] = 16'($urandom_range(0, 1024));
                    phase_cfg[CFG_LAG_FACTOR] = 16'($urandom_range(0, 2047));
                    phase_cfg[CFG_SPACING_OFFSET] = 16'($urandom);
                    phase_cfg[CFG_BEACON_ENABLE] = 16'($urandom_range(0, 1));
                end
            endcase
            write_config(phase_cfg);
            quiet_sender = (ph == 2);
            quiet_receiver = (ph == 3);
            sent = 0;
            while (sent < 80) begin
                // a burst of messages followed by an update, sometimes enough to overflow
                pool = ($urandom_range(0, 3) == 0) ? 24 : 10;
                burst = $urandom_range(0, 3) == 0 ? $urandom_range(14, 22) : $urandom_range(0, 6);
                for (int k = 0; k < burst; k++) begin
                    s = rand_message(pool);
                    if (pool == 24) s.src = 8'(k);
                    send_item(s);
                    sent++;
                end
                s = rand_message(pool);
                s.func = 1'b1;
                send_item(s);
                sent++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
